@@ design/pgm_pkg.sv @@
`timescale 1ns / 1ps
package pgm_pkg;

  typedef enum logic [2:0] {
    PH_MAGIC,
    PH_WIDTH,
    PH_HEIGHT,
    PH_MAXV,
    PH_BIN,
    PH_ASC,
    PH_DRAIN
  } phase_e;

  typedef enum logic [1:0] {
    CS_IDLE,
    CS_DIV,
    CS_OUT
  } ctl_state_e;

  localparam logic [3:0] ST_OK         = 4'd0;
  localparam logic [3:0] ST_MAGIC      = 4'd1;
  localparam logic [3:0] ST_HDR_SHORT  = 4'd2;
  localparam logic [3:0] ST_BAD_NUM    = 4'd3;
  localparam logic [3:0] ST_RANGE      = 4'd4;
  localparam logic [3:0] ST_NO_SEP     = 4'd5;
  localparam logic [3:0] ST_BIN_SHORT  = 4'd6;
  localparam logic [3:0] ST_ASC_SHORT  = 4'd7;
  localparam logic [3:0] ST_OVER_MAX   = 4'd8;
  localparam logic [3:0] ST_BAD_PIXEL  = 4'd9;

  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_2     = 8'h32;
  localparam logic [7:0] CH_5     = 8'h35;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] FULL_SCALE = 8'hff;

  localparam logic [1:0] TERM_EOF  = 2'd0;
  localparam logic [1:0] TERM_WS   = 2'd1;
  localparam logic [1:0] TERM_HASH = 2'd2;

  typedef struct packed {
    logic accept;
    logic div_en;
  } ctrl_cmd_t;

  typedef struct packed {
    logic emit;
    logic need_div;
    logic div_last;
  } dp_status_t;

endpackage

@@ design/pgm_if.sv @@
`timescale 1ns / 1ps
interface pgm_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_file;
  modport source (output valid, output data_byte, output end_of_file, input ready);
  modport sink (input valid, input data_byte, input end_of_file, output ready);
endinterface

interface pgm_pix_if;
  logic        valid;
  logic        ready;
  logic        pixel_valid;
  logic [7:0]  pixel_value;
  logic        pixel_is_last;
  logic        file_done;
  logic [3:0]  status_code;
  logic [15:0] image_width;
  logic [15:0] image_height;
  modport source (output valid, output pixel_valid, output pixel_value,
                  output pixel_is_last, output file_done, output status_code,
                  output image_width, output image_height, input ready);
  modport sink (input valid, input pixel_valid, input pixel_value,
                input pixel_is_last, input file_done, input status_code,
                input image_width, input image_height, output ready);
endinterface

@@ design/pgm_ctrl.sv @@
`timescale 1ns / 1ps
module pgm_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  pgm_pkg::dp_status_t status_i,
  output pgm_pkg::ctrl_cmd_t  cmd_o
);
  import pgm_pkg::*;

  ctl_state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      CS_IDLE: begin
        if (in_valid_i && status_i.emit) begin
          state_d = status_i.need_div ? CS_DIV : CS_OUT;
        end
      end
      CS_DIV: begin
        if (status_i.div_last) begin
          state_d = CS_OUT;
        end
      end
      CS_OUT: begin
        if (out_ready_i) begin
          state_d = CS_IDLE;
        end
      end
      default: state_d = CS_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o   = 1'b0;
    out_valid_o  = 1'b0;
    cmd_o        = '0;
    case (state_q)
      CS_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
      end
      CS_DIV:  cmd_o.div_en = 1'b1;
      CS_OUT:  out_valid_o = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CS_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ design/pgm_datapath.sv @@
`timescale 1ns / 1ps
module pgm_datapath #(
  parameter int DIM_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [7:0]          data_byte_i,
  input  logic                end_of_file_i,
  input  pgm_pkg::ctrl_cmd_t  cmd_i,
  output pgm_pkg::dp_status_t status_o,
  output logic                pixel_valid_o,
  output logic [7:0]          pixel_value_o,
  output logic                pixel_is_last_o,
  output logic                file_done_o,
  output logic [3:0]          status_code_o,
  output logic [15:0]         image_width_o,
  output logic [15:0]         image_height_o
);
  import pgm_pkg::*;

  localparam int TOKW = ((DIM_BITS > 8) ? DIM_BITS : 8) + 1;
  localparam int PLW  = 2 * DIM_BITS;
  localparam logic [TOKW-1:0] TOK_CAP = TOKW'(1) << (TOKW - 1);

  phase_e              phase_q, phase_d;
  logic                bin_q, bin_d;
  logic                cmt_q, cmt_d;
  logic [TOKW-1:0]     tv_q, tv_d;
  logic [2:0]          tl_q, tl_d;
  logic                tb_q, tb_d;
  logic [DIM_BITS-1:0] w_q, w_d;
  logic [DIM_BITS-1:0] h_q, h_d;
  logic [7:0]          mx_q, mx_d;
  logic [PLW-1:0]      pl_q, pl_d;
  logic                hb_q, hb_d;
  logic                hr_q, hr_d;

  logic                r_valid, r_last, r_done, r_emit;
  logic [7:0]          r_pix;
  logic [3:0]          r_status;
  logic                ends;
  logic [1:0]          term;
  logic                is_ws;
  logic [TOKW+3:0]     acc;
  logic [DIM_BITS-1:0] w_out, h_out;

  logic                res_valid_q, res_last_q, res_done_q;
  logic [3:0]          res_status_q;
  logic [15:0]         res_w_q, res_h_q;
  logic [7:0]          quo_q;
  logic [8:0]          rem_q;
  logic [7:0]          lo_q;
  logic [7:0]          dv_q;
  logic [2:0]          cnt_q;
  logic                bypass;
  logic [15:0]         prod;
  logic [8:0]          trial;
  logic [31:0]         w_ext, h_ext;

  always_comb begin
    phase_d = phase_q;
    bin_d   = bin_q;
    cmt_d   = cmt_q;
    tv_d    = tv_q;
    tl_d    = tl_q;
    tb_d    = tb_q;
    w_d     = w_q;
    h_d     = h_q;
    mx_d    = mx_q;
    pl_d    = pl_q;
    hb_d    = hb_q;
    hr_d    = hr_q;
    r_valid = 1'b0;
    r_last  = 1'b0;
    r_done  = 1'b0;
    r_emit  = 1'b0;
    r_pix   = '0;
    r_status = ST_OK;
    ends    = 1'b0;
    term    = TERM_EOF;
    acc     = '0;
    is_ws   = (data_byte_i == CH_SPACE) ||
              ((data_byte_i >= CH_TAB) && (data_byte_i <= CH_CR));

    if (phase_q == PH_BIN) begin
      if (end_of_file_i && (pl_q > PLW'(1))) begin
        r_emit = 1'b1; r_done = 1'b1; r_status = ST_BIN_SHORT; phase_d = PH_DRAIN;
      end else begin
        r_emit = 1'b1; r_valid = 1'b1; r_pix = data_byte_i;
        if (pl_d != '0) pl_d = pl_d - PLW'(1);
        if (pl_d == '0) begin
          r_last = 1'b1; r_done = 1'b1; r_status = ST_OK; phase_d = PH_DRAIN;
        end
      end
    end else if (phase_q != PH_DRAIN) begin
      if (cmt_q) begin
        if (data_byte_i == CH_LF) cmt_d = 1'b0;
      end else if (is_ws || (data_byte_i == CH_HASH)) begin
        if (data_byte_i == CH_HASH) cmt_d = 1'b1;
        if (tl_q != '0) begin
          ends = 1'b1;
          term = (data_byte_i == CH_HASH) ? TERM_HASH : TERM_WS;
        end
      end else begin
        if (phase_q == PH_MAGIC) begin
          if (tl_q == 3'd0) begin
            if (data_byte_i != CH_P) tb_d = 1'b1;
          end else if (tl_q == 3'd1) begin
            if (data_byte_i == CH_5) bin_d = 1'b1;
            else if (data_byte_i == CH_2) bin_d = 1'b0;
            else tb_d = 1'b1;
          end else begin
            tb_d = 1'b1;
          end
        end else if ((data_byte_i >= CH_0) && (data_byte_i <= CH_9)) begin
          acc  = (TOKW+4)'(tv_q) * (TOKW+4)'(10) + (TOKW+4)'(data_byte_i - CH_0);
          tv_d = (acc > (TOKW+4)'(TOK_CAP)) ? TOK_CAP : acc[TOKW-1:0];
        end else begin
          tb_d = 1'b1;
        end
        if (tl_q < 3'd7) tl_d = tl_q + 3'd1;
      end

      if (!ends && end_of_file_i && (tl_d != '0)) begin
        ends = 1'b1;
        term = TERM_EOF;
      end

      if (ends) begin
        case (phase_q)
          PH_MAGIC: begin
            if ((tl_d == 3'd2) && !tb_d) phase_d = PH_WIDTH;
            else begin
              r_emit = 1'b1; r_done = 1'b1; r_status = ST_MAGIC; phase_d = PH_DRAIN;
            end
          end
          PH_WIDTH, PH_HEIGHT: begin
            if (tb_d) hb_d = 1'b1;
            else if ((tv_d == '0) || ((tv_d >> DIM_BITS) != '0)) hr_d = 1'b1;
            if (phase_q == PH_WIDTH) begin
              w_d = tv_d[DIM_BITS-1:0];
              phase_d = PH_HEIGHT;
            end else begin
              h_d = tv_d[DIM_BITS-1:0];
              phase_d = PH_MAXV;
            end
          end
          PH_MAXV: begin
            if (tb_d) hb_d = 1'b1;
            else if ((tv_d == '0) || (tv_d > TOKW'(FULL_SCALE))) hr_d = 1'b1;
            mx_d = tv_d[7:0];
            pl_d = PLW'(w_q) * PLW'(h_q);
            if (hb_d) begin
              r_emit = 1'b1; r_done = 1'b1; r_status = ST_BAD_NUM; phase_d = PH_DRAIN;
            end else if (hr_d) begin
              r_emit = 1'b1; r_done = 1'b1; r_status = ST_RANGE; phase_d = PH_DRAIN;
            end else if (bin_d) begin
              if (term == TERM_WS) phase_d = PH_BIN;
              else begin
                r_emit = 1'b1; r_done = 1'b1; r_status = ST_NO_SEP; phase_d = PH_DRAIN;
              end
            end else begin
              phase_d = PH_ASC;
            end
          end
          PH_ASC: begin
            if (tb_d) begin
              r_emit = 1'b1; r_done = 1'b1; r_status = ST_BAD_PIXEL; phase_d = PH_DRAIN;
            end else if (tv_d > TOKW'(mx_q)) begin
              r_emit = 1'b1; r_done = 1'b1; r_status = ST_OVER_MAX; phase_d = PH_DRAIN;
            end else begin
              r_emit = 1'b1; r_valid = 1'b1; r_pix = tv_d[7:0];
              if (pl_d != '0) pl_d = pl_d - PLW'(1);
              if (pl_d == '0) begin
                r_last = 1'b1; r_done = 1'b1; r_status = ST_OK; phase_d = PH_DRAIN;
              end
            end
          end
          default: ;
        endcase
        tv_d = '0;
        tl_d = '0;
        tb_d = 1'b0;
      end

      if (end_of_file_i && (phase_d != PH_DRAIN)) begin
        if ((phase_d == PH_ASC) && r_valid && !r_done) begin
          r_valid = 1'b0;
          r_pix   = '0;
        end
        case (phase_d)
          PH_MAGIC: begin
            r_emit = 1'b1; r_done = 1'b1; r_status = ST_MAGIC; phase_d = PH_DRAIN;
          end
          PH_WIDTH, PH_HEIGHT, PH_MAXV: begin
            r_emit = 1'b1; r_done = 1'b1; r_status = ST_HDR_SHORT; phase_d = PH_DRAIN;
          end
          PH_ASC: begin
            r_emit = 1'b1; r_done = 1'b1; r_status = ST_ASC_SHORT; phase_d = PH_DRAIN;
          end
          PH_BIN: begin
            r_emit = 1'b1; r_done = 1'b1; r_status = ST_BIN_SHORT; phase_d = PH_DRAIN;
          end
          default: ;
        endcase
      end
    end

    w_out = w_d;
    h_out = h_d;

    if ((phase_d == PH_DRAIN) && end_of_file_i) begin
      phase_d = PH_MAGIC;
      bin_d   = 1'b0;
      cmt_d   = 1'b0;
      tv_d    = '0;
      tl_d    = '0;
      tb_d    = 1'b0;
      w_d     = '0;
      h_d     = '0;
      mx_d    = '0;
      pl_d    = '0;
      hb_d    = 1'b0;
      hr_d    = 1'b0;
    end
  end

  // rescale: saturated cases bypass the divider
  assign bypass = (mx_q == '0) || (r_pix >= mx_q);
  assign prod   = {r_pix, 8'h00} - {8'h00, r_pix};
  assign trial  = {rem_q[7:0], lo_q[7]};

  assign status_o.emit     = r_emit;
  assign status_o.need_div = r_valid && !bypass;
  assign status_o.div_last = (cnt_q == 3'd7);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_MAGIC;
      bin_q   <= 1'b0;
      cmt_q   <= 1'b0;
      tv_q    <= '0;
      tl_q    <= '0;
      tb_q    <= 1'b0;
      w_q     <= '0;
      h_q     <= '0;
      mx_q    <= '0;
      pl_q    <= '0;
      hb_q    <= 1'b0;
      hr_q    <= 1'b0;
      cnt_q   <= '0;
    end else if (cmd_i.accept) begin
      phase_q <= phase_d;
      bin_q   <= bin_d;
      cmt_q   <= cmt_d;
      tv_q    <= tv_d;
      tl_q    <= tl_d;
      tb_q    <= tb_d;
      w_q     <= w_d;
      h_q     <= h_d;
      mx_q    <= mx_d;
      pl_q    <= pl_d;
      hb_q    <= hb_d;
      hr_q    <= hr_d;
      cnt_q   <= '0;
    end else if (cmd_i.div_en) begin
      cnt_q   <= cnt_q + 3'd1;
    end
  end

  // divisor is held apart from mx_q, which clears when the file ends
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && r_emit) begin
      res_valid_q  <= r_valid;
      res_last_q   <= r_last;
      res_done_q   <= r_done;
      res_status_q <= r_status;
      res_w_q      <= w_ext[15:0];
      res_h_q      <= h_ext[15:0];
      quo_q        <= (mx_q == '0) ? r_pix : FULL_SCALE;
      rem_q        <= {1'b0, prod[15:8]};
      lo_q         <= prod[7:0];
      dv_q         <= mx_q;
    end else if (cmd_i.div_en) begin
      lo_q <= {lo_q[6:0], 1'b0};
      if (trial >= {1'b0, dv_q}) begin
        rem_q <= trial - {1'b0, dv_q};
        quo_q <= {quo_q[6:0], 1'b1};
      end else begin
        rem_q <= trial;
        quo_q <= {quo_q[6:0], 1'b0};
      end
    end
  end

  assign w_ext = 32'(w_out);
  assign h_ext = 32'(h_out);

  assign pixel_valid_o   = res_valid_q;
  assign pixel_value_o   = res_valid_q ? quo_q : 8'h00;
  assign pixel_is_last_o = res_last_q;
  assign file_done_o     = res_done_q;
  assign status_code_o   = res_status_q;
  assign image_width_o   = res_w_q;
  assign image_height_o  = res_h_q;

endmodule

@@ design/pgm_stream_parser_core.sv @@
`timescale 1ns / 1ps
// Streaming PGM (P2/P5) decoder. One file byte is taken per transaction on byte_i;
// a byte that produces no result is simply consumed, a byte that ends the file
// with a status has its result registered and held on pix_o, and a byte that
// yields a pixel is rescaled as pixel*255/maxval by the eight-step restoring
// divider, which saturated pixels bypass. Results are held until taken, and the
// next byte is taken once the previous result has gone. Pixels stream before the
// end of the image, so a later nonzero status_code means they must be discarded.
module pgm_stream_parser_core #(
  parameter int DIM_BITS = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  pgm_byte_if.sink  byte_i,
  pgm_pix_if.source pix_o
);
  import pgm_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  pgm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (byte_i.valid),
    .in_ready_o  (byte_i.ready),
    .out_valid_o (pix_o.valid),
    .out_ready_i (pix_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  pgm_datapath #(
    .DIM_BITS (DIM_BITS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .data_byte_i     (byte_i.data_byte),
    .end_of_file_i   (byte_i.end_of_file),
    .cmd_i           (cmd),
    .status_o        (status),
    .pixel_valid_o   (pix_o.pixel_valid),
    .pixel_value_o   (pix_o.pixel_value),
    .pixel_is_last_o (pix_o.pixel_is_last),
    .file_done_o     (pix_o.file_done),
    .status_code_o   (pix_o.status_code),
    .image_width_o   (pix_o.image_width),
    .image_height_o  (pix_o.image_height)
  );

endmodule
